FILE: hdl/stable_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// stable_priority_queue_defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// concurrent assertion on the rising clock, muted while in reset
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the stable priority queue
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned TAG_BITS_DEF = 32;
  localparam int unsigned TAG_W        = 32;
  localparam int unsigned AGE_W        = 8;

  // input commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_GIVEN    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [AGE_W-1:0]  age;
    logic              female;
  } cell_ctrl_t;

endpackage

FILE: hdl/spq_in_if.sv
// ---------------------------------------------------------------------------
// spq_in_if
// command channel of the stable priority queue
// ---------------------------------------------------------------------------
interface spq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        cmd;
  logic [spq_pkg::TAG_W-1:0]         entry_tag;
  logic [spq_pkg::AGE_W-1:0]         age;
  logic                              is_female;

  modport source (output valid, output cmd, output entry_tag, output age,
                  output is_female, input ready);
  modport sink   (input valid, input cmd, input entry_tag, input age,
                  input is_female, output ready);
endinterface

FILE: hdl/spq_out_if.sv
// ---------------------------------------------------------------------------
// spq_out_if
// result channel of the stable priority queue
// ---------------------------------------------------------------------------
interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [spq_pkg::TAG_W-1:0]         out_tag;
  logic [spq_pkg::AGE_W-1:0]         out_age;
  logic                              out_female;
  logic                              last;

  modport source (output valid, output status, output out_tag, output out_age,
                  output out_female, output last, input ready);
  modport sink   (input valid, input status, input out_tag, input out_age,
                  input out_female, input last, output ready);
endinterface

FILE: hdl/stable_priority_queue.sv
// ---------------------------------------------------------------------------
// stable_priority_queue
// sorted priority queue built as a chain of slot cells
// ---------------------------------------------------------------------------
// usage
//   req_i carries commands: insert (tag, age, female flag), pop head, list all.
//   rsp_o carries results: status, entry fields and a last marker.
//   order is age descending, female before male at equal age, and fifo
//   among equal keys; every cell compares itself with a new entry at once,
//   so an insert or pop shifts the whole chain together
// results
//   insert and pop results are registered and show on rsp_o the cycle
//   after the transaction; unused commands give no result
//   list gives one result per cycle while rsp_o keeps taking them, head
//   first, by rotating the chain one place per result; req_i is held off
//   until the last result is loaded
// reset
//   occupancy and control clear; slot contents are left as they are
// stall
//   a single output register holds the pending result; while it is full
//   and rsp_o.ready is low, nothing moves and req_i.ready stays low
// ---------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int unsigned DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spq_in_if.sink       req_i,
  spq_out_if.source    rsp_o
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned TW    = spq_pkg::TAG_W;
  localparam int unsigned AW    = spq_pkg::AGE_W;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e              state_q, state_d;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic [OCC_W-1:0]    rem_q, rem_d;
  logic                rsp_valid_q, rsp_valid_d;
  spq_pkg::status_e    status_q, status_d;
  logic [TW-1:0]       out_tag_q, out_tag_d;
  logic [AW-1:0]       out_age_q, out_age_d;
  logic                out_female_q, out_female_d;
  logic                last_q, last_d;

  // chain wiring
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_gb;
  logic [TAG_BITS-1:0] cell_tag    [DEPTH];
  logic [AW-1:0]       cell_age    [DEPTH];
  logic                cell_female [DEPTH];
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::cell_op_e   op;
  logic [TAG_BITS-1:0] new_tag;

  logic out_free;
  logic accept;
  logic is_full;
  logic is_empty;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign is_full     = (occ_q == OCC_W'(DEPTH));
  assign is_empty    = (occ_q == '0);
  assign new_tag     = TAG_BITS'(req_i.entry_tag);

  assign ctrl.op     = op;
  assign ctrl.age    = req_i.age;
  assign ctrl.female = req_i.is_female;

  // occupancy as a thermometer: slots below it hold entries
  for (genvar g = 0; g < DEPTH; g++) begin : g_valid
    assign cell_valid[g] = (occ_q > OCC_W'(g));
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned P = (g == 0) ? 0 : g - 1;
    localparam int unsigned N = (g == DEPTH - 1) ? g : g + 1;

    spq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_tag_i     (new_tag),
      .valid_i       (cell_valid[g]),
      .nxt_valid_i   ((g == DEPTH - 1) ? 1'b0 : cell_valid[N]),
      .gb_prev_i     ((g == 0) ? 1'b0 : cell_gb[P]),
      .prev_tag_i    (cell_tag[P]),
      .prev_age_i    (cell_age[P]),
      .prev_female_i (cell_female[P]),
      .nxt_tag_i     (cell_tag[N]),
      .nxt_age_i     (cell_age[N]),
      .nxt_female_i  (cell_female[N]),
      .head_tag_i    (cell_tag[0]),
      .head_age_i    (cell_age[0]),
      .head_female_i (cell_female[0]),
      .gb_o          (cell_gb[g]),
      .tag_o         (cell_tag[g]),
      .age_o         (cell_age[g]),
      .female_o      (cell_female[g])
    );
  end

  // command decode and result formation
  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    rem_d        = rem_q;
    op           = spq_pkg::OP_HOLD;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    status_d     = status_q;
    out_tag_d    = out_tag_q;
    out_age_d    = out_age_q;
    out_female_d = out_female_q;
    last_d       = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_tag_d    = '0;
          out_age_d    = '0;
          out_female_d = 1'b0;
          last_d       = 1'b1;
          priority if (req_i.cmd == spq_pkg::CMD_INSERT) begin
            rsp_valid_d = 1'b1;
            if (is_full) begin
              status_d = spq_pkg::ST_FULL;
            end else begin
              status_d = spq_pkg::ST_INSERTED;
              op       = spq_pkg::OP_INSERT;
              occ_d    = occ_q + OCC_W'(1);
            end
          end else if (req_i.cmd == spq_pkg::CMD_POP) begin
            rsp_valid_d = 1'b1;
            if (is_empty) begin
              status_d = spq_pkg::ST_EMPTY;
            end else begin
              status_d     = spq_pkg::ST_GIVEN;
              out_tag_d    = TW'(cell_tag[0]);
              out_age_d    = cell_age[0];
              out_female_d = cell_female[0];
              op           = spq_pkg::OP_POP;
              occ_d        = occ_q - OCC_W'(1);
            end
          end else if (req_i.cmd == spq_pkg::CMD_LIST) begin
            rsp_valid_d = 1'b1;
            if (is_empty) begin
              status_d = spq_pkg::ST_EMPTY;
            end else begin
              status_d     = spq_pkg::ST_GIVEN;
              out_tag_d    = TW'(cell_tag[0]);
              out_age_d    = cell_age[0];
              out_female_d = cell_female[0];
              op           = spq_pkg::OP_ROTATE;
              rem_d        = occ_q - OCC_W'(1);
              last_d       = (occ_q == OCC_W'(1));
              if (occ_q != OCC_W'(1)) begin
                state_d = S_LIST;
              end
            end
          end else begin
            // unused command: no result
            rsp_valid_d = rsp_valid_q && !rsp_o.ready;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          status_d     = spq_pkg::ST_GIVEN;
          out_tag_d    = TW'(cell_tag[0]);
          out_age_d    = cell_age[0];
          out_female_d = cell_female[0];
          last_d       = (rem_q == OCC_W'(1));
          op           = spq_pkg::OP_ROTATE;
          rem_d        = rem_q - OCC_W'(1);
          if (rem_q == OCC_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      rem_q        <= '0;
      rsp_valid_q  <= 1'b0;
      status_q     <= spq_pkg::ST_INSERTED;
      out_tag_q    <= '0;
      out_age_q    <= '0;
      out_female_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      rem_q        <= rem_d;
      rsp_valid_q  <= rsp_valid_d;
      status_q     <= status_d;
      out_tag_q    <= out_tag_d;
      out_age_q    <= out_age_d;
      out_female_q <= out_female_d;
      last_q       <= last_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.out_tag    = out_tag_q;
  assign rsp_o.out_age    = out_age_q;
  assign rsp_o.out_female = out_female_q;
  assign rsp_o.last       = last_q;

endmodule

FILE: hdl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry and trades with its neighbours
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                       clk_i,
  input  spq_pkg::cell_ctrl_t        ctrl_i,
  input  logic [TAG_BITS-1:0]        new_tag_i,
  input  logic                       valid_i,
  input  logic                       nxt_valid_i,
  input  logic                       gb_prev_i,
  input  logic [TAG_BITS-1:0]        prev_tag_i,
  input  logic [spq_pkg::AGE_W-1:0]  prev_age_i,
  input  logic                       prev_female_i,
  input  logic [TAG_BITS-1:0]        nxt_tag_i,
  input  logic [spq_pkg::AGE_W-1:0]  nxt_age_i,
  input  logic                       nxt_female_i,
  input  logic [TAG_BITS-1:0]        head_tag_i,
  input  logic [spq_pkg::AGE_W-1:0]  head_age_i,
  input  logic                       head_female_i,
  output logic                       gb_o,
  output logic [TAG_BITS-1:0]        tag_o,
  output logic [spq_pkg::AGE_W-1:0]  age_o,
  output logic                       female_o
);

  logic [TAG_BITS-1:0]        tag_q, tag_d;
  logic [spq_pkg::AGE_W-1:0]  age_q, age_d;
  logic                       female_q, female_d;

  // new entry belongs in front of this slot (an empty slot always qualifies)
  assign gb_o = !valid_i || (ctrl_i.age > age_q) ||
                ((ctrl_i.age == age_q) && ctrl_i.female && !female_q);

  always_comb begin
    tag_d    = tag_q;
    age_d    = age_q;
    female_d = female_q;
    unique case (ctrl_i.op)
      spq_pkg::OP_INSERT: begin
        if (gb_o && gb_prev_i) begin
          tag_d    = prev_tag_i;
          age_d    = prev_age_i;
          female_d = prev_female_i;
        end else if (gb_o) begin
          tag_d    = new_tag_i;
          age_d    = ctrl_i.age;
          female_d = ctrl_i.female;
        end
      end
      spq_pkg::OP_POP: begin
        tag_d    = nxt_tag_i;
        age_d    = nxt_age_i;
        female_d = nxt_female_i;
      end
      spq_pkg::OP_ROTATE: begin
        // valid entries move one towards the head, the head wraps to the tail
        if (nxt_valid_i) begin
          tag_d    = nxt_tag_i;
          age_d    = nxt_age_i;
          female_d = nxt_female_i;
        end else if (valid_i) begin
          tag_d    = head_tag_i;
          age_d    = head_age_i;
          female_d = head_female_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    age_q    <= age_d;
    female_q <= female_d;
  end

  assign tag_o    = tag_q;
  assign age_o    = age_q;
  assign female_o = female_q;

endmodule

FILE: hdl/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// port-level checks of the stable priority queue, bound to the top level
// ---------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 status_i,
  input logic [spq_pkg::TAG_W-1:0]  out_tag_i,
  input logic [spq_pkg::AGE_W-1:0]  out_age_i,
  input logic                       out_female_i,
  input logic                       last_i
);

  logic not_given;

  assign not_given = out_valid_i && (status_i != spq_pkg::ST_GIVEN);

  `SPQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped under stall")
  `SPQ_ASSERT_IMP(a_zero_fields, clk_i, rst_ni, not_given, (out_tag_i == '0) && (out_age_i == '0) && !out_female_i, "payload not zero on a status-only result")
  `SPQ_ASSERT_IMP(a_single_last, clk_i, rst_ni, not_given, last_i, "status-only result without last")
  `SPQ_ASSERT_IMP(a_list_blocks, clk_i, rst_ni, out_valid_i && !last_i, !in_ready_i, "command taken in the middle of a list")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .out_tag_i    (rsp_o.out_tag),
  .out_age_i    (rsp_o.out_age),
  .out_female_i (rsp_o.out_female),
  .last_i       (rsp_o.last)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the stable priority queue: a scoreboard keeps a
// sorted copy of the queue, predicts every result of each accepted command
// and compares the result stream field by field under random idling
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned QUEUE_DEPTH = spq_pkg::DEPTH_DEF;
  localparam int unsigned TW          = spq_pkg::TAG_W;
  localparam int unsigned AW          = spq_pkg::AGE_W;
  localparam int          CYCLE_LIMIT = 200000;
  // cmd 3 has no name in the package; the block must swallow it silently
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  // the receiver holds off once after this many command transactions
  localparam int          HOLD_AFTER  = 70;
  localparam int          HOLD_CYCLES = 150;
  localparam int          RANDOM_CMDS = 140;

  // one command as planned by the stimulus
  typedef struct {
    logic [1:0]    cmd;
    logic [TW-1:0] tag;
    logic [AW-1:0] age;
    logic          female;
    bit            drain_first;   // hold this one back until all results are in
  } cmd_item_t;

  // one slot of the queue
  typedef struct {
    logic [TW-1:0] tag;
    logic [AW-1:0] age;
    logic          female;
  } slot_t;

  // one result transaction
  typedef struct {
    spq_pkg::status_e status;
    logic [TW-1:0]    tag;
    logic [AW-1:0]    age;
    logic             female;
    logic             last;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  stable_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  cmd_item_t pending_cmds[$];     // commands not yet offered to the block
  slot_t     queue_image[$];      // sorted image of the queue, head first
  result_t   expected_results[$]; // results still owed by the block
  int        accepted_cmds = 0;
  int        total_cmds    = 0;
  int        error_count   = 0;
  int        cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // scoreboard: applies one accepted command to the queue image and queues
  // the results that it must give
  // ---------------------------------------------------------------------------
  function automatic result_t make_result(spq_pkg::status_e st, slot_t s, logic lst);
    result_t r;
    r.status = st;
    r.tag    = s.tag;
    r.age    = s.age;
    r.female = s.female;
    r.last   = lst;
    return r;
  endfunction

  function automatic void apply_queue_command(cmd_item_t c);
    slot_t blank;
    slot_t fresh;
    int    pos;
    blank = '{tag: '0, age: '0, female: 1'b0};
    fresh = '{tag: c.tag, age: c.age, female: c.female};
    case (c.cmd)
      spq_pkg::CMD_INSERT: begin
        if (queue_image.size() >= QUEUE_DEPTH) begin
          expected_results.push_back(make_result(spq_pkg::ST_FULL, blank, 1'b1));
        end else begin
          // first slot the newcomer outranks; ties keep arrival order
          pos = queue_image.size();
          for (int i = 0; i < queue_image.size(); i++) begin
            if (c.age > queue_image[i].age ||
                (c.age == queue_image[i].age && c.female && !queue_image[i].female)) begin
              pos = i;
              break;
            end
          end
          queue_image.insert(pos, fresh);
          expected_results.push_back(make_result(spq_pkg::ST_INSERTED, blank, 1'b1));
        end
      end
      spq_pkg::CMD_POP: begin
        if (queue_image.size() == 0) begin
          expected_results.push_back(make_result(spq_pkg::ST_EMPTY, blank, 1'b1));
        end else begin
          expected_results.push_back(make_result(spq_pkg::ST_GIVEN,
                                                 queue_image.pop_front(), 1'b1));
        end
      end
      spq_pkg::CMD_LIST: begin
        if (queue_image.size() == 0) begin
          expected_results.push_back(make_result(spq_pkg::ST_EMPTY, blank, 1'b1));
        end else begin
          foreach (queue_image[i]) begin
            expected_results.push_back(make_result(spq_pkg::ST_GIVEN, queue_image[i],
                                                   i == queue_image.size() - 1));
          end
        end
      end
      default: ;  // unused command: no result, nothing changes
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------
  task automatic plan_cmd(logic [1:0] cmd, logic [TW-1:0] tag, logic [AW-1:0] age,
                          logic female, bit drain_first);
    pending_cmds.push_back('{cmd: cmd, tag: tag, age: age, female: female,
                             drain_first: drain_first});
  endtask

  function automatic logic [AW-1:0] pick_age();
    int roll;
    roll = $urandom_range(0, 9);
    // mostly a narrow band so that equal keys and ties on the flag are common
    if (roll < 5) return AW'($urandom_range(0, 3));
    if (roll < 7) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    return AW'($urandom_range(0, 255));
  endfunction

  task automatic plan_random_cmds();
    int made;
    int phase;
    int phase_left;
    int roll;
    bit drain_done;
    logic [1:0] cmd;
    made       = 0;
    phase      = 0;
    phase_left = 0;
    drain_done = 1'b0;
    while (made < RANDOM_CMDS) begin
      if (phase_left == 0) begin
        // fill-heavy, drain-heavy or balanced stretches walk the queue
        // between empty and full again and again
        phase      = $urandom_range(0, 2);
        phase_left = $urandom_range(10, 30);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        cmd = CMD_UNUSED;
      end else if (roll < 11) begin
        cmd = spq_pkg::CMD_LIST;
      end else begin
        case (phase)
          0:       cmd = (roll < 80) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_POP;
          1:       cmd = (roll < 35) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_POP;
          default: cmd = (roll < 56) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_POP;
        endcase
      end
      plan_cmd(cmd, TW'($urandom()), pick_age(), 1'($urandom_range(0, 1)),
               !drain_done && made == 120);
      if (made == 120) drain_done = 1'b1;
      if (cmd != CMD_UNUSED) made++;
    end
  endtask

  task automatic plan_directed_cmds();
    // empty queue: pop and list both report empty, cmd 3 gives nothing
    plan_cmd(spq_pkg::CMD_POP,    32'h0, 8'h00, 1'b0, 1'b0);
    plan_cmd(spq_pkg::CMD_LIST,   32'h0, 8'h00, 1'b0, 1'b0);
    plan_cmd(CMD_UNUSED,          32'hffff_ffff, 8'hff, 1'b1, 1'b0);
    // extremes of tag and age, flag order at equal age, fifo among equal keys
    plan_cmd(spq_pkg::CMD_INSERT, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
    plan_cmd(spq_pkg::CMD_INSERT, 32'hffff_ffff, 8'hff, 1'b1, 1'b0);
    plan_cmd(spq_pkg::CMD_INSERT, 32'h5555_5555, 8'hff, 1'b0, 1'b0);
    plan_cmd(spq_pkg::CMD_INSERT, 32'haaaa_aaaa, 8'hff, 1'b1, 1'b0);
    plan_cmd(spq_pkg::CMD_INSERT, 32'h0000_0001, 8'h00, 1'b0, 1'b0);
    plan_cmd(spq_pkg::CMD_INSERT, 32'h8000_0000, 8'h00, 1'b1, 1'b0);
    plan_cmd(spq_pkg::CMD_LIST,   32'h0, 8'h00, 1'b0, 1'b0);
    plan_cmd(spq_pkg::CMD_POP,    32'h0, 8'h00, 1'b0, 1'b0);
    plan_cmd(spq_pkg::CMD_POP,    32'h0, 8'h00, 1'b0, 1'b0);
    // top up to full, then one more that must be dropped
    for (int i = 0; i < 12; i++) begin
      plan_cmd(spq_pkg::CMD_INSERT, TW'($urandom()), AW'($urandom_range(0, 2)),
               1'($urandom_range(0, 1)), 1'b0);
    end
    plan_cmd(spq_pkg::CMD_INSERT, 32'hdead_beef, 8'hff, 1'b1, 1'b0);
    plan_cmd(spq_pkg::CMD_LIST,   32'h0, 8'h00, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers planned commands in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  cmd_item_t offered_cmd;
  bit        offering   = 1'b0;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      offering     = 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_queue_command(offered_cmd);
        accepted_cmds++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
          offered_cmd         = pending_cmds.pop_front();
          offering            = 1'b1;
          req_if.cmd          <= offered_cmd.cmd;
          req_if.entry_tag    <= offered_cmd.tag;
          req_if.age          <= offered_cmd.age;
          req_if.is_female    <= offered_cmd.female;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // now and then a long burst with no gap at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      req_if.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: switches between patterns, plus one long hold-off while
  // the driver keeps offering so the block backs up into its input
  // ---------------------------------------------------------------------------
  int   ready_mode = 0;
  int   mode_left  = 0;
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;
  logic ready_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (!hold_done && accepted_cmds >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0:       ready_next = 1'b1;
          1:       ready_next = 1'($urandom_range(0, 1));
          default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      rsp_if.ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transaction is checked against the oldest
  // expectation
  // ---------------------------------------------------------------------------
  result_t wanted;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d tag %h", rsp_if.status,
               rsp_if.out_tag);
        error_count++;
      end else begin
        wanted = expected_results.pop_front();
        if (rsp_if.status !== wanted.status) begin
          $error("status: expected %0d, got %0d", wanted.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.out_tag !== wanted.tag) begin
          $error("out_tag: expected %h, got %h", wanted.tag, rsp_if.out_tag);
          error_count++;
        end
        if (rsp_if.out_age !== wanted.age) begin
          $error("out_age: expected %0d, got %0d", wanted.age, rsp_if.out_age);
          error_count++;
        end
        if (rsp_if.out_female !== wanted.female) begin
          $error("out_female: expected %0d, got %0d", wanted.female, rsp_if.out_female);
          error_count++;
        end
        if (rsp_if.last !== wanted.last) begin
          $error("last: expected %0d, got %0d", wanted.last, rsp_if.last);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: reset, plan, then wait for everything to drain
  // ---------------------------------------------------------------------------
  initial begin
    req_if.valid     = 1'b0;
    req_if.cmd       = spq_pkg::CMD_INSERT;
    req_if.entry_tag = '0;
    req_if.age       = '0;
    req_if.is_female = 1'b0;
    rsp_if.ready     = 1'b0;

    plan_directed_cmds();
    // let the full queue and its listing drain out before random traffic
    plan_cmd(spq_pkg::CMD_POP, 32'h0, 8'h00, 1'b0, 1'b1);
    plan_random_cmds();
    total_cmds = pending_cmds.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds < total_cmds) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // tail: anything extra would show up here
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
